// ===== sv/dpgs_pkg.sv =====
package dpgs_pkg;

   localparam int PATTERN_SLOTS = 8;
   localparam int DEF_MAX_STEPS = 32;

   localparam int CV_W       = 12;
   localparam int FRAC_W     = 11;
   localparam int PROD_W     = CV_W + FRAC_W;
   localparam int FRAC_SHIFT = 5;
   localparam int LERP_SHIFT = 16;
   localparam int LERP_DROP  = LERP_SHIFT - FRAC_SHIFT;

   localparam int SLOT_SHIFT   = 9;
   localparam int OFFSET_SHIFT = 8;
   localparam int SLOT_W       = 3;
   localparam int OFF_W        = CV_W - OFFSET_SHIFT;
   localparam int OFFSET_MAX   = (1 << OFF_W) - 1;

   localparam int OP_W       = 2;
   localparam int TSTEP_W    = 5;
   localparam int TLEN_W     = 6;
   localparam int MOD_IDX_W  = 3;

   localparam logic [OP_W-1:0] OP_STEP = 2'd0;
   localparam logic [OP_W-1:0] OP_BIT  = 2'd1;
   localparam logic [OP_W-1:0] OP_LEN  = 2'd2;

   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] LM_OR    = 2'd0;
   localparam logic [MODE_W-1:0] LM_AND   = 2'd1;
   localparam logic [MODE_W-1:0] LM_XOR   = 2'd2;
   localparam logic [MODE_W-1:0] LM_LATCH = 2'd3;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_LOGIC_MODE = 1'b0;

   typedef struct packed {
      logic                 capture;
      logic                 wr_bit;
      logic                 wr_len;
      logic                 mul;
      logic                 blend;
      logic                 len_load;
      logic                 mod_en;
      logic [MOD_IDX_W-1:0] mod_idx;
      logic                 mem_rd;
      logic                 finish;
   } dpgs_cmd_type;

endpackage

// ===== sv/dpgs_ctrl.sv =====
module dpgs_ctrl
   import dpgs_pkg::*;
#(
   parameter int MAX_STEPS = DEF_MAX_STEPS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [OP_W-1:0] req_operation,
   output logic            busy,
   output dpgs_cmd_type    cmd
);

   localparam int SUM_W = $clog2(MAX_STEPS + OFFSET_MAX + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_ADD  = 3'd2;
   localparam logic [2:0] ST_LEN  = 3'd3;
   localparam logic [2:0] ST_MOD  = 3'd4;
   localparam logic [2:0] ST_READ = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [MOD_IDX_W-1:0] idx_ff, idx_in;
   logic                 accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = accept && (req_operation == OP_STEP);
            cmd.wr_bit  = accept && (req_operation == OP_BIT);
            cmd.wr_len  = accept && (req_operation == OP_LEN);
            if (cmd.capture) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.blend = 1'b1;
            state_in  = ST_LEN;
         end
         ST_LEN: begin
            cmd.len_load = 1'b1;
            idx_in       = MOD_IDX_W'(SUM_W - 1);
            state_in     = ST_MOD;
         end
         ST_MOD: begin
            cmd.mod_en  = 1'b1;
            cmd.mod_idx = idx_ff;
            if (idx_ff == '0) begin
               state_in = ST_READ;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== sv/dpgs_datapath.sv =====
module dpgs_datapath
   import dpgs_pkg::*;
#(
   parameter int MAX_STEPS = DEF_MAX_STEPS
) (
   input  logic               clock,
   input  logic               reset,
   input  dpgs_cmd_type       cmd,
   input  logic [MODE_W-1:0]  logic_mode,
   input  logic [CV_W-1:0]    req_knob_a,
   input  logic [CV_W-1:0]    req_knob_offset,
   input  logic [CV_W-1:0]    req_knob_b,
   input  logic [CV_W-1:0]    req_cv_a,
   input  logic [CV_W-1:0]    req_cv_offset,
   input  logic [CV_W-1:0]    req_cv_b,
   input  logic               req_table_track,
   input  logic [SLOT_W-1:0]  req_table_slot,
   input  logic [TSTEP_W-1:0] req_table_step,
   input  logic               req_table_bit,
   input  logic [TLEN_W-1:0]  req_table_length,
   output logic               rsp_strobe,
   output logic               rsp_gate_a,
   output logic               rsp_gate_b,
   output logic               rsp_logic_gate
);

   localparam int STEP_W = $clog2(MAX_STEPS);
   localparam int LEN_W  = $clog2(MAX_STEPS + 1);
   localparam int SUM_W  = $clog2(MAX_STEPS + OFFSET_MAX + 1);
   localparam int CMP_W  = SUM_W + LEN_W;
   localparam int DEPTH  = PATTERN_SLOTS * MAX_STEPS;
   localparam int ADDR_W = $clog2(DEPTH);

   function automatic logic [LEN_W-1:0] eff_len(input logic [TLEN_W-1:0] stored);
      logic [LEN_W-1:0] len;
      if (stored == '0) begin
         len = LEN_W'(1);
      end else if (int'(stored) > MAX_STEPS) begin
         len = LEN_W'(MAX_STEPS);
      end else begin
         len = LEN_W'(stored);
      end
      return len;
   endfunction

   // blend lanes: 0 track A slot, 1 offset, 2 track B slot
   logic [CV_W-1:0]   knob_ff [3];
   logic [CV_W-1:0]   knob_in [3];
   logic [CV_W-1:0]   cv_ff [3];
   logic [CV_W-1:0]   cv_in [3];
   logic [CV_W-1:0]   lo_ff [3];
   logic [CV_W-1:0]   lo_in [3];
   logic [PROD_W-1:0] prod_ff [3];
   logic [PROD_W-1:0] prod_in [3];
   logic [CV_W-1:0]   inv_w [3];
   logic [CV_W-1:0]   diff_w [3];
   logic [CV_W-1:0]   val_w [3];

   logic [SLOT_W-1:0] slot_a_ff, slot_a_in;
   logic [SLOT_W-1:0] slot_b_ff, slot_b_in;
   logic [OFF_W-1:0]  off_ff, off_in;

   logic [TLEN_W-1:0] len_a_ff [PATTERN_SLOTS];
   logic [TLEN_W-1:0] len_b_ff [PATTERN_SLOTS];
   logic [LEN_W-1:0]  div_a_ff, div_a_in;
   logic [LEN_W-1:0]  div_b_ff, div_b_in;

   // remainder lanes: 0 read A, 1 read B, 2 next count A, 3 next count B
   logic [SUM_W-1:0]  rem_ff [4];
   logic [SUM_W-1:0]  rem_in [4];
   logic [LEN_W-1:0]  lane_div [4];
   logic [CMP_W-1:0]  div_sh [4];

   logic [STEP_W-1:0] cnt_a_ff, cnt_a_in;
   logic [STEP_W-1:0] cnt_b_ff, cnt_b_in;
   logic              latch_ff, latch_in;
   logic              strobe_ff;
   logic              gate_a_ff, gate_b_ff, logic_gate_ff;
   logic              new_gate;

   logic              pat_a_ff [DEPTH];
   logic              pat_b_ff [DEPTH];
   logic              bit_a_ff, bit_b_ff;
   logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic              step_ok;

   assign knob_in[0] = cmd.capture ? req_knob_a      : knob_ff[0];
   assign knob_in[1] = cmd.capture ? req_knob_offset : knob_ff[1];
   assign knob_in[2] = cmd.capture ? req_knob_b      : knob_ff[2];
   assign cv_in[0]   = cmd.capture ? req_cv_a        : cv_ff[0];
   assign cv_in[1]   = cmd.capture ? req_cv_offset   : cv_ff[1];
   assign cv_in[2]   = cmd.capture ? req_cv_b        : cv_ff[2];

   // inv >= half: lerp(knob, full); else lerp(0, knob); frac is inv's low bits either way
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         inv_w[i]  = ~cv_ff[i];
         diff_w[i] = inv_w[i][CV_W-1] ? ~knob_ff[i] : knob_ff[i];
         lo_in[i]  = cmd.mul ? (inv_w[i][CV_W-1] ? knob_ff[i] : '0) : lo_ff[i];
         prod_in[i] = cmd.mul ? PROD_W'(diff_w[i]) * PROD_W'(inv_w[i][FRAC_W-1:0])
                              : prod_ff[i];
         val_w[i]  = lo_ff[i] + CV_W'(prod_ff[i] >> LERP_DROP);
      end
   end

   assign slot_a_in = cmd.blend ? SLOT_W'(val_w[0] >> SLOT_SHIFT)   : slot_a_ff;
   assign off_in    = cmd.blend ? OFF_W'(val_w[1] >> OFFSET_SHIFT)  : off_ff;
   assign slot_b_in = cmd.blend ? SLOT_W'(val_w[2] >> SLOT_SHIFT)   : slot_b_ff;

   assign div_a_in = cmd.len_load ? eff_len(len_a_ff[slot_a_ff]) : div_a_ff;
   assign div_b_in = cmd.len_load ? eff_len(len_b_ff[slot_b_ff]) : div_b_ff;

   assign lane_div[0] = div_a_ff;
   assign lane_div[1] = div_b_ff;
   assign lane_div[2] = div_a_ff;
   assign lane_div[3] = div_b_ff;

   // restoring remainder, one quotient bit per cycle
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         div_sh[l] = CMP_W'(lane_div[l]) << cmd.mod_idx;
         rem_in[l] = rem_ff[l];
         if (cmd.mod_en && (CMP_W'(rem_ff[l]) >= div_sh[l])) begin
            rem_in[l] = rem_ff[l] - SUM_W'(div_sh[l]);
         end
      end
      if (cmd.len_load) begin
         rem_in[0] = SUM_W'(cnt_a_ff) + SUM_W'(off_ff);
         rem_in[1] = SUM_W'(cnt_b_ff);
         rem_in[2] = SUM_W'(cnt_a_ff) + SUM_W'(1);
         rem_in[3] = SUM_W'(cnt_b_ff) + SUM_W'(1);
      end
   end

   assign step_ok   = (int'(req_table_step) < MAX_STEPS);
   assign wr_addr   = ADDR_W'(int'(req_table_slot) * MAX_STEPS + int'(req_table_step));
   assign rd_addr_a = ADDR_W'(int'(slot_a_ff) * MAX_STEPS + int'(rem_ff[0]));
   assign rd_addr_b = ADDR_W'(int'(slot_b_ff) * MAX_STEPS + int'(rem_ff[1]));

   always_ff @(posedge clock) begin
      if (cmd.wr_bit && step_ok && !req_table_track) begin
         pat_a_ff[wr_addr] <= req_table_bit;
      end
      if (cmd.mem_rd) begin
         bit_a_ff <= pat_a_ff[rd_addr_a];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_bit && step_ok && req_table_track) begin
         pat_b_ff[wr_addr] <= req_table_bit;
      end
      if (cmd.mem_rd) begin
         bit_b_ff <= pat_b_ff[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_len && !req_table_track) begin
         len_a_ff[req_table_slot] <= req_table_length;
      end
      if (cmd.wr_len && req_table_track) begin
         len_b_ff[req_table_slot] <= req_table_length;
      end
   end

   always_comb begin
      unique case (logic_mode)
         LM_OR:    new_gate = bit_a_ff | bit_b_ff;
         LM_AND:   new_gate = bit_a_ff & bit_b_ff;
         LM_XOR:   new_gate = bit_a_ff ^ bit_b_ff;
         LM_LATCH: new_gate = latch_ff ? bit_a_ff : bit_b_ff;
      endcase
   end

   assign latch_in = cmd.finish ? new_gate : latch_ff;
   assign cnt_a_in = cmd.finish ? STEP_W'(rem_ff[2]) : cnt_a_ff;
   assign cnt_b_in = cmd.finish ? STEP_W'(rem_ff[3]) : cnt_b_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         knob_ff[i] <= knob_in[i];
         cv_ff[i]   <= cv_in[i];
         lo_ff[i]   <= lo_in[i];
         prod_ff[i] <= prod_in[i];
      end
      for (int l = 0; l < 4; l++) begin
         rem_ff[l] <= rem_in[l];
      end
      slot_a_ff <= slot_a_in;
      slot_b_ff <= slot_b_in;
      off_ff    <= off_in;
      div_a_ff  <= div_a_in;
      div_b_ff  <= div_b_in;
      if (cmd.finish) begin
         gate_a_ff     <= bit_a_ff;
         gate_b_ff     <= bit_b_ff;
         logic_gate_ff <= new_gate;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff  <= '0;
         cnt_b_ff  <= '0;
         latch_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         cnt_a_ff  <= cnt_a_in;
         cnt_b_ff  <= cnt_b_in;
         latch_ff  <= latch_in;
         strobe_ff <= cmd.finish;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_gate_a     = gate_a_ff;
   assign rsp_gate_b     = gate_b_ff;
   assign rsp_logic_gate = logic_gate_ff;

endmodule

// ===== sv/dual_pattern_gate_sequencer.sv =====
// Dual rhythm gate sequencer. Load words (pattern bit, slot length) leave
// busy low and give no result. A clock-step word keeps busy high through
// the multiply, blend, length-load, modulo, table-read and output states;
// no new word is taken until busy falls. The step counters and read
// addresses come from the remainder unit, one quotient bit per cycle for
// each of the four modulo-length lanes. rsp_strobe marks the result on
// rsp_* for one cycle, as busy falls; the receiver cannot stall it, so it
// must take every strobe. logic_mode should be written while idle.
module dual_pattern_gate_sequencer
   import dpgs_pkg::*;
#(
   parameter int MAX_STEPS = DEF_MAX_STEPS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [CV_W-1:0]       req_knob_a,
   input  logic [CV_W-1:0]       req_knob_offset,
   input  logic [CV_W-1:0]       req_knob_b,
   input  logic [CV_W-1:0]       req_cv_a,
   input  logic [CV_W-1:0]       req_cv_offset,
   input  logic [CV_W-1:0]       req_cv_b,
   input  logic                  req_table_track,
   input  logic [SLOT_W-1:0]     req_table_slot,
   input  logic [TSTEP_W-1:0]    req_table_step,
   input  logic                  req_table_bit,
   input  logic [TLEN_W-1:0]     req_table_length,
   output logic                  rsp_strobe,
   output logic                  rsp_gate_a,
   output logic                  rsp_gate_b,
   output logic                  rsp_logic_gate,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   dpgs_cmd_type      cmd;
   logic [MODE_W-1:0] logic_mode_ff, logic_mode_in;
   logic              csr_wr;
   logic              csr_hit;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_W-1:2] == REG_LOGIC_MODE);
   assign csr_wr  = psel && penable && pwrite && pready && csr_hit;
   assign logic_mode_in = csr_wr ? pwdata[MODE_W-1:0] : logic_mode_ff;
   assign prdata  = csr_hit ? CSR_DATA_W'(logic_mode_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         logic_mode_ff <= LM_OR;
      end else begin
         logic_mode_ff <= logic_mode_in;
      end
   end

   dpgs_ctrl #(
      .MAX_STEPS (MAX_STEPS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .busy          (busy),
      .cmd           (cmd)
   );

   dpgs_datapath #(
      .MAX_STEPS (MAX_STEPS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .logic_mode       (logic_mode_ff),
      .req_knob_a       (req_knob_a),
      .req_knob_offset  (req_knob_offset),
      .req_knob_b       (req_knob_b),
      .req_cv_a         (req_cv_a),
      .req_cv_offset    (req_cv_offset),
      .req_cv_b         (req_cv_b),
      .req_table_track  (req_table_track),
      .req_table_slot   (req_table_slot),
      .req_table_step   (req_table_step),
      .req_table_bit    (req_table_bit),
      .req_table_length (req_table_length),
      .rsp_strobe       (rsp_strobe),
      .rsp_gate_a       (rsp_gate_a),
      .rsp_gate_b       (rsp_gate_b),
      .rsp_logic_gate   (rsp_logic_gate)
   );

endmodule
